/* sv/tmh_pkg.sv */
package tmh_pkg;

  localparam int unsigned DefaultCapacity = 64;
  localparam int unsigned DeadlineW = 64;
  localparam int unsigned TaskW = 16;
  localparam int unsigned KindW = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned OccW = 7;

  localparam logic [KindW-1:0] KIND_INSERT = 2'd0;
  localparam logic [KindW-1:0] KIND_POP = 2'd1;
  localparam logic [KindW-1:0] KIND_PEEK = 2'd2;
  localparam logic [KindW-1:0] KIND_UNUSED = 2'd3;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED = 3'd0,
    ST_REJECTED = 3'd1,
    ST_EXPIRED  = 3'd2,
    ST_NONE     = 3'd3,
    ST_PEEK     = 3'd4
  } status_e;

  typedef struct packed {
    logic [DeadlineW-1:0] deadline;
    logic [TaskW-1:0]     task_tag;
  } entry_t;

  typedef struct packed {
    status_e              status;
    logic [TaskW-1:0]     expired_task;
    logic [DeadlineW-1:0] time_value;
    logic [OccW-1:0]      expired_count;
    logic [OccW-1:0]      occupancy;
    logic                 last;
  } result_t;

  function automatic result_t make_result(status_e st, logic [TaskW-1:0] tsk,
                                          logic [DeadlineW-1:0] tv,
                                          logic [OccW-1:0] cnt,
                                          logic [OccW-1:0] occ, logic lst);
    result_t r;
    r.status = st;
    r.expired_task = tsk;
    r.time_value = tv;
    r.expired_count = cnt;
    r.occupancy = occ;
    r.last = lst;
    return r;
  endfunction

endpackage

/* sv/timer_min_heap.sv */
// Binary min-heap of timers with CAPACITY entries, stored in one synchronous RAM with two
// read ports and one write port. Every result is registered and shows in the cycle after
// the edge that produces it. A rejected insert, a peek of an empty heap and an undefined
// kind never raise busy; the first two give their result in the cycle after acceptance.
// An accepted insert keeps busy high while the entry climbs; each level it climbs takes
// S_UP_RD and S_UP_CMP, and it is written in S_UP_RD when it reaches the root or in
// S_UP_CMP when it stops below it. A peek of a nonempty heap passes through S_PEEK. A pop
// reads and checks the root in S_POP_RD and S_POP_CHK (only S_POP_RD when the heap is
// empty); each removal adds S_DN_RD and S_DN_CMP per level the moved entry descends; the
// entry is written in S_DN_RD or S_DN_CMP where it settles, and the removal's result is
// shown when the following root check ends. Each level costs one RAM read and one
// compare. Results come out on res_valid_o for a single cycle and cannot be stalled;
// busy stays high until the final result of an item, marked by last_o, is on the ports.
module timer_min_heap #(
  parameter int unsigned CAPACITY = tmh_pkg::DefaultCapacity
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [tmh_pkg::KindW-1:0]      kind_i,
  input  logic [tmh_pkg::DeadlineW-1:0]  deadline_i,
  input  logic [tmh_pkg::TaskW-1:0]      task_tag_i,
  input  logic [tmh_pkg::DeadlineW-1:0]  now_time_i,
  output logic                           res_valid_o,
  output logic [tmh_pkg::StatusW-1:0]    status_o,
  output logic [tmh_pkg::TaskW-1:0]      expired_task_o,
  output logic [tmh_pkg::DeadlineW-1:0]  time_value_o,
  output logic [tmh_pkg::OccW-1:0]       expired_count_o,
  output logic [tmh_pkg::OccW-1:0]       occupancy_o,
  output logic                           last_o
);
  import tmh_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = AW + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_PEEK, S_POP_RD, S_POP_CHK, S_DN_RD, S_DN_CMP
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      n_q;
  logic [AW-1:0]      pos_q;
  entry_t             move_q;
  entry_t             pend_q;
  logic [DeadlineW-1:0] now_q;
  result_t            res_q;
  logic               res_valid_q;

  entry_t             mem [CAPACITY];
  entry_t             rd_a_q;
  entry_t             rd_b_q;
  logic [AW-1:0]      ra;
  logic [AW-1:0]      rb;
  logic               we;
  logic [AW-1:0]      waddr;
  entry_t             wdata;

  logic [AW-1:0]      parent;
  logic [AW-1:0]      last_addr;
  logic [IW-1:0]      lc_w;
  logic [IW-1:0]      rc_w;
  logic [IW-1:0]      cnt_w;
  logic               lc_ok;
  logic               rc_ok;
  logic               use_r;
  entry_t             child;
  logic [AW-1:0]      child_addr;
  logic               descend;
  logic               climb;
  logic               take;

  assign parent = (pos_q - 1'b1) >> 1;
  assign last_addr = AW'(count_q - 1'b1);
  assign lc_w = {1'b0, pos_q, 1'b1};
  assign rc_w = lc_w + 1'b1;
  assign cnt_w = IW'(count_q);
  assign lc_ok = lc_w < cnt_w;
  assign rc_ok = rc_w < cnt_w;
  assign use_r = rc_ok && (rd_b_q.deadline < rd_a_q.deadline);
  assign child = use_r ? rd_b_q : rd_a_q;
  assign child_addr = use_r ? rc_w[AW-1:0] : lc_w[AW-1:0];
  assign descend = child.deadline < move_q.deadline;
  assign climb = move_q.deadline < rd_a_q.deadline;
  assign take = rd_a_q.deadline <= now_q;

  always_comb begin
    we = 1'b0;
    waddr = pos_q;
    wdata = move_q;
    ra = '0;
    rb = '0;
    unique case (state_q)
      S_UP_RD: begin
        if (pos_q == '0) begin
          we = 1'b1;
        end else begin
          ra = parent;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (climb) begin
          wdata = rd_a_q;
        end
      end
      S_POP_RD: begin
        rb = last_addr;
      end
      S_DN_RD: begin
        if (!lc_ok) begin
          we = 1'b1;
        end else begin
          ra = lc_w[AW-1:0];
          rb = rc_ok ? rc_w[AW-1:0] : lc_w[AW-1:0];
        end
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (descend) begin
          wdata = child;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_q <= mem[ra];
    rd_b_q <= mem[rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      n_q <= '0;
      pos_q <= '0;
      move_q <= '0;
      pend_q <= '0;
      now_q <= '0;
      res_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            unique case (kind_i)
              KIND_INSERT: begin
                if (task_tag_i == '0 || count_q == CW'(CAPACITY)) begin
                  res_q <= make_result(ST_REJECTED, '0, '0, '0, OccW'(count_q), 1'b1);
                  res_valid_q <= 1'b1;
                end else begin
                  move_q <= '{deadline: deadline_i, task_tag: task_tag_i};
                  pos_q <= AW'(count_q);
                  state_q <= S_UP_RD;
                end
              end
              KIND_POP: begin
                now_q <= now_time_i;
                n_q <= '0;
                state_q <= S_POP_RD;
              end
              KIND_PEEK: begin
                if (count_q == '0) begin
                  res_q <= make_result(ST_PEEK, '0, '1, '0, '0, 1'b1);
                  res_valid_q <= 1'b1;
                end else begin
                  state_q <= S_PEEK;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_UP_RD: begin
          if (pos_q == '0) begin
            count_q <= count_q + 1'b1;
            res_q <= make_result(ST_INSERTED, '0, '0, '0, OccW'(count_q + 1'b1), 1'b1);
            res_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (climb) begin
            pos_q <= parent;
            state_q <= S_UP_RD;
          end else begin
            count_q <= count_q + 1'b1;
            res_q <= make_result(ST_INSERTED, '0, '0, '0, OccW'(count_q + 1'b1), 1'b1);
            res_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_PEEK: begin
          res_q <= make_result(ST_PEEK, '0, rd_a_q.deadline, '0, OccW'(count_q), 1'b1);
          res_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        S_POP_RD: begin
          if (count_q == '0) begin
            if (n_q == '0) begin
              res_q <= make_result(ST_NONE, '0, '0, '0, '0, 1'b1);
            end else begin
              res_q <= make_result(ST_EXPIRED, pend_q.task_tag, pend_q.deadline,
                                   OccW'(n_q), '0, 1'b1);
            end
            res_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_POP_CHK;
          end
        end
        S_POP_CHK: begin
          if (n_q != '0) begin
            res_q <= make_result(ST_EXPIRED, pend_q.task_tag, pend_q.deadline,
                                 OccW'(n_q), OccW'(count_q), !take);
            res_valid_q <= 1'b1;
          end
          if (take) begin
            pend_q <= rd_a_q;
            n_q <= n_q + 1'b1;
            count_q <= count_q - 1'b1;
            move_q <= rd_b_q;
            pos_q <= '0;
            state_q <= (count_q == CW'(1)) ? S_POP_RD : S_DN_RD;
          end else begin
            if (n_q == '0) begin
              res_q <= make_result(ST_NONE, '0, '0, '0, OccW'(count_q), 1'b1);
              res_valid_q <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        S_DN_RD: begin
          state_q <= lc_ok ? S_DN_CMP : S_POP_RD;
        end
        S_DN_CMP: begin
          if (descend) begin
            pos_q <= child_addr;
            state_q <= S_DN_RD;
          end else begin
            state_q <= S_POP_RD;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign status_o = res_q.status;
  assign expired_task_o = res_q.expired_task;
  assign time_value_o = res_q.time_value;
  assign expired_count_o = res_q.expired_count;
  assign occupancy_o = res_q.occupancy;
  assign last_o = res_q.last;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("heap count exceeds capacity");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && last_o |-> !busy)
    else $error("final result shown while still busy");

  a_expired_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o == ST_EXPIRED |-> expired_count_o != '0)
    else $error("expired result without a removal count");

  a_write_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> IW'(waddr) <= cnt_w)
    else $error("write beyond the end of the heap");

  a_undefined_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && kind_i == KIND_UNUSED |=> !res_valid_o && !busy)
    else $error("undefined kind caused activity");

endmodule

/* tb/sv/timer_min_heap_tb.sv */
module timer_min_heap_tb;
  import tmh_pkg::*;

  localparam int unsigned HeapDepth = DefaultCapacity;
  localparam logic [DeadlineW-1:0] NEVER = '1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [KindW-1:0]     kind_i;
  logic [DeadlineW-1:0] deadline_i;
  logic [TaskW-1:0]     task_tag_i;
  logic [DeadlineW-1:0] now_time_i;
  logic                 res_valid_o;
  logic [StatusW-1:0]   status_o;
  logic [TaskW-1:0]     expired_task_o;
  logic [DeadlineW-1:0] time_value_o;
  logic [OccW-1:0]      expired_count_o;
  logic [OccW-1:0]      occupancy_o;
  logic                 last_o;

  // Shadow copy of the heap and the replies it says the block owes.
  logic [DeadlineW-1:0] shadow_deadline[HeapDepth];
  logic [TaskW-1:0]     shadow_task[HeapDepth];
  int unsigned          shadow_count;
  result_t              replies_due[$];

  int                   error_count;
  int unsigned          idle_pct;

  timer_min_heap DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .deadline_i     (deadline_i),
    .task_tag_i     (task_tag_i),
    .now_time_i     (now_time_i),
    .res_valid_o    (res_valid_o),
    .status_o       (status_o),
    .expired_task_o (expired_task_o),
    .time_value_o   (time_value_o),
    .expired_count_o(expired_count_o),
    .occupancy_o    (occupancy_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void swap_shadow(int unsigned a, int unsigned b);
    logic [DeadlineW-1:0] d;
    logic [TaskW-1:0] t;
    d = shadow_deadline[a];
    t = shadow_task[a];
    shadow_deadline[a] = shadow_deadline[b];
    shadow_task[a] = shadow_task[b];
    shadow_deadline[b] = d;
    shadow_task[b] = t;
  endfunction

  function automatic void bubble_up(int unsigned pos);
    int unsigned parent;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (shadow_deadline[pos] >= shadow_deadline[parent]) break;
      swap_shadow(pos, parent);
      pos = parent;
    end
  endfunction

  function automatic void bubble_down(int unsigned pos);
    int unsigned lc;
    int unsigned rc;
    int unsigned best;
    forever begin
      lc = 2 * pos + 1;
      rc = 2 * pos + 2;
      best = pos;
      if (lc < shadow_count && shadow_deadline[lc] < shadow_deadline[best]) best = lc;
      if (rc < shadow_count && shadow_deadline[rc] < shadow_deadline[best]) best = rc;
      if (best == pos) break;
      swap_shadow(pos, best);
      pos = best;
    end
  endfunction

  function automatic void queue_reply(status_e st, logic [TaskW-1:0] tsk,
                                      logic [DeadlineW-1:0] tv, logic [OccW-1:0] cnt,
                                      logic lst);
    result_t r;
    r.status = st;
    r.expired_task = tsk;
    r.time_value = tv;
    r.expired_count = cnt;
    r.occupancy = OccW'(shadow_count);
    r.last = lst;
    replies_due.push_back(r);
  endfunction

  function automatic void apply_timer_op(logic [KindW-1:0] kind, logic [DeadlineW-1:0] dl,
                                         logic [TaskW-1:0] tag, logic [DeadlineW-1:0] now);
    int unsigned removed;
    logic [TaskW-1:0] t;
    logic [DeadlineW-1:0] d;
    logic fin;
    removed = 0;
    case (kind)
      KIND_INSERT: begin
        if (tag == '0 || shadow_count >= HeapDepth) begin
          queue_reply(ST_REJECTED, '0, '0, '0, 1'b1);
        end else begin
          shadow_deadline[shadow_count] = dl;
          shadow_task[shadow_count] = tag;
          bubble_up(shadow_count);
          shadow_count++;
          queue_reply(ST_INSERTED, '0, '0, '0, 1'b1);
        end
      end
      KIND_POP: begin
        while (shadow_count > 0 && shadow_deadline[0] <= now && removed < HeapDepth) begin
          t = shadow_task[0];
          d = shadow_deadline[0];
          shadow_count--;
          shadow_deadline[0] = shadow_deadline[shadow_count];
          shadow_task[0] = shadow_task[shadow_count];
          if (shadow_count > 0) bubble_down(0);
          fin = (shadow_count == 0) || (shadow_deadline[0] > now);
          removed++;
          queue_reply(ST_EXPIRED, t, d, OccW'(removed), fin);
        end
        if (removed == 0) queue_reply(ST_NONE, '0, '0, '0, 1'b1);
      end
      KIND_PEEK: begin
        queue_reply(ST_PEEK, '0, (shadow_count == 0) ? NEVER : shadow_deadline[0], '0, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk_i) begin : check_replies
    result_t want;
    if (rst_ni && res_valid_o) begin
      if (replies_due.size() == 0) begin
        $error("unexpected result: status %0d task %0h", status_o, expired_task_o);
        error_count++;
      end else begin
        want = replies_due.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
        if (expired_task_o !== want.expired_task) begin
          $error("expired_task: expected %0h, got %0h", want.expired_task, expired_task_o);
          error_count++;
        end
        if (time_value_o !== want.time_value) begin
          $error("time_value: expected %0h, got %0h", want.time_value, time_value_o);
          error_count++;
        end
        if (expired_count_o !== want.expired_count) begin
          $error("expired_count: expected %0d, got %0d", want.expired_count,
                 expired_count_o);
          error_count++;
        end
        if (occupancy_o !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          error_count++;
        end
      end
    end
  end

  task automatic send_item(input logic [KindW-1:0] kind, input logic [DeadlineW-1:0] dl,
                           input logic [TaskW-1:0] tag, input logic [DeadlineW-1:0] now);
    @(negedge clk_i);
    kind_i = kind;
    deadline_i = dl;
    task_tag_i = tag;
    now_time_i = now;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    apply_timer_op(kind, dl, tag, now);
    if ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
  endtask

  function automatic logic [DeadlineW-1:0] any_time();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [DeadlineW-1:0] pick_deadline();
    case ($urandom_range(0, 11))
      0: return any_time();
      1: return NEVER;
      2: return '0;
      default: return DeadlineW'($urandom_range(0, 2000));
    endcase
  endfunction

  function automatic logic [DeadlineW-1:0] pick_now();
    case ($urandom_range(0, 11))
      0: return any_time();
      1: return '0;
      default: return DeadlineW'($urandom_range(0, 2200));
    endcase
  endfunction

  task automatic test_directed();
    send_item(KIND_PEEK, any_time(), 16'h0000, any_time());
    send_item(KIND_POP, any_time(), 16'hFFFF, NEVER);
    send_item(KIND_INSERT, 64'd5, 16'h0000, any_time());
    send_item(KIND_INSERT, 64'd500, 16'hFFFF, '0);
    send_item(KIND_INSERT, 64'd0, 16'h0001, NEVER);
    send_item(KIND_INSERT, NEVER, 16'h8000, '0);
    send_item(KIND_INSERT, 64'd500, 16'h1234, '0);
    send_item(KIND_INSERT, 64'd300, 16'h00FF, '0);
    send_item(KIND_INSERT, 64'd500, 16'h5555, '0);
    send_item(KIND_PEEK, NEVER, 16'hFFFF, NEVER);
    send_item(KIND_POP, NEVER, 16'h0000, 64'd0);
    send_item(KIND_POP, '0, 16'h0000, 64'd299);
    send_item(KIND_POP, '0, 16'h0000, 64'd500);
    send_item(KIND_UNUSED, 64'd7, 16'h0007, NEVER);
    send_item(KIND_PEEK, '0, 16'h0000, '0);
    send_item(KIND_POP, '0, 16'h0000, NEVER - 1);
    send_item(KIND_POP, '0, 16'h0000, NEVER);
    send_item(KIND_PEEK, '0, 16'h0000, '0);
    send_item(KIND_INSERT, any_time(), 16'hAAAA, NEVER);
    send_item(KIND_POP, '0, 16'h0000, NEVER);
  endtask

  task automatic test_full_heap();
    repeat (HeapDepth - shadow_count)
      send_item(KIND_INSERT, pick_deadline(), 16'($urandom_range(1, 65535)), any_time());
    send_item(KIND_INSERT, 64'd1, 16'h0101, any_time());
    send_item(KIND_INSERT, 64'd1, 16'h0000, any_time());
    send_item(KIND_PEEK, any_time(), 16'($urandom), any_time());
    send_item(KIND_POP, any_time(), 16'($urandom), NEVER);
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned pick;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)
        send_item(KIND_INSERT, pick_deadline(), 16'h0000, any_time());
      else if (pick < 60)
        send_item(KIND_INSERT, pick_deadline(), 16'($urandom_range(1, 65535)), any_time());
      else if (pick < 78)
        send_item(KIND_POP, any_time(), 16'($urandom), pick_now());
      else if (pick < 95)
        send_item(KIND_PEEK, any_time(), 16'($urandom), any_time());
      else
        send_item(KIND_UNUSED, any_time(), 16'($urandom), any_time());
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    kind_i = KIND_INSERT;
    deadline_i = '0;
    task_tag_i = '0;
    now_time_i = '0;
    shadow_count = 0;
    error_count = 0;
    idle_pct = 11;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(15);
    idle_pct = 63;
    test_full_heap();
    test_random(15);
    idle_pct = 0;
    test_random(15);

    @(negedge clk_i);
    start = 1'b0;
    do @(posedge clk_i); while (replies_due.size() != 0 || busy);
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && replies_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
